>>> design/vtvd_pkg.sv
// Shared constants, codes and types of the vertex transform and divide block.
// No dependencies; every other design file depends on this package.
package vtvd_pkg;

    localparam int COORD_BITS = 32;
    localparam int FRAC_BITS  = 16;
    localparam int SIZE_BITS  = 13;
    localparam int ELEM_IDX_W = 4;
    localparam int DIM        = 4;
    localparam int MAT_SIZE   = DIM * DIM;

    // Datapath widths
    localparam int PROD_W    = 2 * COORD_BITS;
    localparam int ACC_W     = PROD_W + 2;
    localparam int VP_W      = COORD_BITS + SIZE_BITS + 3;
    localparam int NUM_W     = VP_W + FRAC_BITS;
    localparam int DEN_W     = COORD_BITS + 1;
    localparam int Q_BITS    = DEN_W;
    localparam int REM_W     = DEN_W + 1;
    localparam int NUM_LANES = 3;

    // Configuration port
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 32;
    localparam logic [CFG_INDEX_W-1:0] REG_RENDER_WIDTH  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_RENDER_HEIGHT = CFG_INDEX_W'(1);
    localparam logic [SIZE_BITS-1:0]   RESET_WIDTH  = SIZE_BITS'(640);
    localparam logic [SIZE_BITS-1:0]   RESET_HEIGHT = SIZE_BITS'(480);

    // Lane numbers of the divider
    localparam int LANE_X = 0;
    localparam int LANE_Y = 1;
    localparam int LANE_Z = 2;

    localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam logic signed [COORD_BITS-1:0] COORD_ONE = COORD_BITS'(1) <<< FRAC_BITS;
    localparam logic [Q_BITS-1:0] LIMIT_POS = Q_BITS'(COORD_MAX);
    localparam logic [Q_BITS-1:0] LIMIT_NEG = LIMIT_POS + Q_BITS'(1);

    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_VERTEX = 1'b1
    } opcode_t;

    // Sideband that travels with each vertex
    typedef struct packed {
        logic batch_end;
        logic fault;
    } vtvd_tag_t;

    // One division: magnitude of scaled numerator, divisor, result sign
    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
        logic             neg;
    } div_op_t;

    // Raw quotient of one lane
    typedef struct packed {
        logic [Q_BITS-1:0] quot;
        logic              ovf;
        logic              neg;
    } div_res_t;

endpackage

>>> design/vtvd_if.sv
// Channel interfaces: vertex input, result output and configuration write.
// Depends on vtvd_pkg for field widths.
interface vtvd_in_if;
    logic                                    valid;
    logic                                    ready;
    logic                                    opcode;
    logic [vtvd_pkg::ELEM_IDX_W-1:0]         element_index;
    logic signed [vtvd_pkg::COORD_BITS-1:0]  element_value;
    logic signed [vtvd_pkg::COORD_BITS-1:0]  vertex_x;
    logic signed [vtvd_pkg::COORD_BITS-1:0]  vertex_y;
    logic signed [vtvd_pkg::COORD_BITS-1:0]  vertex_z;
    logic signed [vtvd_pkg::COORD_BITS-1:0]  vertex_w;
    logic                                    end_of_batch;

    modport source (output valid, opcode, element_index, element_value,
                    vertex_x, vertex_y, vertex_z, vertex_w, end_of_batch, input ready);
    modport sink   (input valid, opcode, element_index, element_value,
                    vertex_x, vertex_y, vertex_z, vertex_w, end_of_batch, output ready);
endinterface

interface vtvd_out_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [vtvd_pkg::COORD_BITS-1:0]  screen_x;
    logic signed [vtvd_pkg::COORD_BITS-1:0]  screen_y;
    logic signed [vtvd_pkg::COORD_BITS-1:0]  depth;
    logic                                    batch_end;
    logic                                    divide_fault;

    modport source (output valid, screen_x, screen_y, depth, batch_end, divide_fault,
                    input ready);
    modport sink   (input valid, screen_x, screen_y, depth, batch_end, divide_fault,
                    output ready);
endinterface

interface vtvd_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [vtvd_pkg::CFG_INDEX_W-1:0]     index;
    logic [vtvd_pkg::CFG_DATA_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> design/vertex_transform_viewport_divide_core.sv
// Top level of the vertex transform, viewport map and perspective divide block.
// Depends on vtvd_pkg, vtvd_if, vtvd_transform and vtvd_divider.
//
// Usage:
//   vertex : input channel. opcode OP_LOAD writes one element of the 4x4
//            column-major clip matrix and yields no result; OP_VERTEX
//            transforms one vertex and yields one result.
//   result : screen_x, screen_y, depth (Q16.16, saturated), batch_end and
//            divide_fault (zero transformed w or any saturation).
//   cfg    : register writes, always ready; index 0 render width, 1 height.
// Throughput is one transfer per cycle while the receiver does not stall. A
// result passes four transform stages, 34 divider stages (a seed stage, then
// one quotient bit per stage for 33 bits) and the output register.
// Reset loads the identity matrix and a 640 x 480 render size and empties
// the pipeline. When the receiver stalls, the whole pipeline holds and
// vertex.ready drops; nothing is lost or repeated. Loads take effect for
// every vertex transferred after them.
module vertex_transform_viewport_divide_core (
    input logic clk,
    input logic rst_n,
    vtvd_in_if.sink    vertex,
    vtvd_out_if.source result,
    vtvd_cfg_if.sink   cfg
);
    import vtvd_pkg::*;

    logic [SIZE_BITS-1:0] width_reg, height_reg;
    logic                 adv;
    logic                 xf_valid, div_valid;
    div_op_t  [NUM_LANES-1:0] xf_ops;
    div_res_t [NUM_LANES-1:0] div_res;
    vtvd_tag_t            xf_tag, div_tag;

    logic                         out_valid_reg;
    logic signed [COORD_BITS-1:0] res_reg  [NUM_LANES];
    logic signed [COORD_BITS-1:0] res_next [NUM_LANES];
    logic                         be_reg, fault_reg, fault_next;

    // Advance the pipeline unless a result waits
    assign adv          = !out_valid_reg || result.ready;
    assign vertex.ready = adv;
    assign cfg.ready    = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RESET_WIDTH;
            height_reg <= RESET_HEIGHT;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == REG_RENDER_WIDTH)
                width_reg <= cfg.data[SIZE_BITS-1:0];
            else if (cfg.index == REG_RENDER_HEIGHT)
                height_reg <= cfg.data[SIZE_BITS-1:0];
        end
    end

    vtvd_transform u_xf (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .load_en   (vertex.valid && adv && (vertex.opcode == OP_LOAD)),
        .load_idx  (vertex.element_index),
        .load_val  (vertex.element_value),
        .vert_en   (vertex.valid && (vertex.opcode == OP_VERTEX)),
        .vx        (vertex.vertex_x),
        .vy        (vertex.vertex_y),
        .vz        (vertex.vertex_z),
        .vw        (vertex.vertex_w),
        .batch_end (vertex.end_of_batch),
        .render_w  (width_reg),
        .render_h  (height_reg),
        .out_valid (xf_valid),
        .out_ops   (xf_ops),
        .out_tag   (xf_tag)
    );

    vtvd_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (xf_valid),
        .in_ops    (xf_ops),
        .in_tag    (xf_tag),
        .out_valid (div_valid),
        .out_res   (div_res),
        .out_tag   (div_tag)
    );

    // Apply sign and saturate each quotient
    always_comb
    begin
        fault_next = div_tag.fault;
        for (int l = 0; l < NUM_LANES; l++)
        begin
            if (div_res[l].ovf ||
                (div_res[l].quot > (div_res[l].neg ? LIMIT_NEG : LIMIT_POS)))
            begin
                fault_next  = 1'b1;
                res_next[l] = div_res[l].neg ? COORD_MIN : COORD_MAX;
            end
            else if (div_res[l].neg)
                res_next[l] = COORD_BITS'(-div_res[l].quot);
            else
                res_next[l] = COORD_BITS'(div_res[l].quot);
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= div_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg   <= res_next;
            be_reg    <= div_tag.batch_end;
            fault_reg <= fault_next;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.screen_x     = res_reg[LANE_X];
    assign result.screen_y     = res_reg[LANE_Y];
    assign result.depth        = res_reg[LANE_Z];
    assign result.batch_end    = be_reg;
    assign result.divide_fault = fault_reg;

`ifndef SYNTHESIS
    // Input is only held off while a finished result waits
    a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !vertex.ready |-> (result.valid && !result.ready))
        else $error("vertex input stalled without a waiting result");

    // A divider result never vanishes while the output is stalled
    a_div_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (div_valid && !adv) |=> div_valid)
        else $error("divider result lost during stall");

    // An overflowed X or Z quotient always raises the fault flag
    a_sat_fault: assert property (@(posedge clk) disable iff (!rst_n)
        (div_valid && adv && (div_res[LANE_Z].ovf || div_res[LANE_X].ovf))
        |=> result.divide_fault)
        else $error("overflowed division without fault flag");
`endif

endmodule

>>> design/vtvd_transform.sv
// Matrix store, matrix multiply, clip saturation, viewport map and divide set-up.
// Four register stages; depends on vtvd_pkg.
module vtvd_transform (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 adv,
    input  logic                                 load_en,
    input  logic [vtvd_pkg::ELEM_IDX_W-1:0]      load_idx,
    input  logic signed [vtvd_pkg::COORD_BITS-1:0] load_val,
    input  logic                                 vert_en,
    input  logic signed [vtvd_pkg::COORD_BITS-1:0] vx,
    input  logic signed [vtvd_pkg::COORD_BITS-1:0] vy,
    input  logic signed [vtvd_pkg::COORD_BITS-1:0] vz,
    input  logic signed [vtvd_pkg::COORD_BITS-1:0] vw,
    input  logic                                 batch_end,
    input  logic [vtvd_pkg::SIZE_BITS-1:0]       render_w,
    input  logic [vtvd_pkg::SIZE_BITS-1:0]       render_h,
    output logic                                 out_valid,
    output vtvd_pkg::div_op_t [vtvd_pkg::NUM_LANES-1:0] out_ops,
    output vtvd_pkg::vtvd_tag_t                  out_tag
);
    import vtvd_pkg::*;

    logic signed [COORD_BITS-1:0] mat_reg [MAT_SIZE];
    logic signed [COORD_BITS-1:0] vin     [DIM];

    logic                         s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic signed [PROD_W-1:0]     prod_reg [DIM][DIM];
    logic signed [PROD_W-1:0]     prod_next [DIM][DIM];
    logic                         s1_be_reg;
    logic signed [COORD_BITS-1:0] clip_reg [DIM];
    logic signed [COORD_BITS-1:0] clip_next [DIM];
    logic                         clip_fault_next;
    vtvd_tag_t                    s2_tag_reg, s3_tag_reg;
    logic signed [VP_W-1:0]       nx_reg, ny_reg, nx_next, ny_next;
    logic signed [COORD_BITS-1:0] cz_reg, cw_reg;
    div_op_t [NUM_LANES-1:0]      ops_reg, ops_next;
    vtvd_tag_t                    s4_tag_reg;

    assign vin[0] = vx;
    assign vin[1] = vy;
    assign vin[2] = vz;
    assign vin[3] = vw;

    // Write one matrix element per load transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAT_SIZE; i++)
                mat_reg[i] <= (i % (DIM + 1) == 0) ? COORD_ONE : '0;
        end
        else if (load_en)
        begin
            mat_reg[load_idx] <= load_val;
        end
    end

    // Stage 1: sixteen full products
    always_comb
    begin
        for (int r = 0; r < DIM; r++)
            for (int k = 0; k < DIM; k++)
                prod_next[r][k] = PROD_W'(mat_reg[k * DIM + r]) * PROD_W'(vin[k]);
    end

    // Stage 2: sum each row, floor shift, saturate
    always_comb
    begin
        logic signed [ACC_W-1:0] acc;
        logic signed [ACC_W-1:0] shf;
        clip_fault_next = 1'b0;
        for (int r = 0; r < DIM; r++)
        begin
            acc = ACC_W'(prod_reg[r][0]) + ACC_W'(prod_reg[r][1])
                + ACC_W'(prod_reg[r][2]) + ACC_W'(prod_reg[r][3]);
            shf = acc >>> FRAC_BITS;
            if ((&shf[ACC_W-1:COORD_BITS-1]) || !(|shf[ACC_W-1:COORD_BITS-1]))
                clip_next[r] = shf[COORD_BITS-1:0];
            else
            begin
                clip_next[r] = shf[ACC_W-1] ? COORD_MIN : COORD_MAX;
                clip_fault_next = 1'b1;
            end
        end
    end

    // Stage 3: viewport map in half units
    always_comb
    begin
        logic signed [VP_W-1:0] we, wm1, he, hm1;
        we  = VP_W'({1'b0, render_w});
        he  = VP_W'({1'b0, render_h});
        wm1 = we - VP_W'(1);
        hm1 = he - VP_W'(1);
        nx_next = VP_W'(clip_reg[0]) * we + wm1 * VP_W'(clip_reg[3]);
        ny_next = hm1 * VP_W'(clip_reg[3]) - VP_W'(clip_reg[1]) * he;
    end

    // Stage 4: magnitudes and signs for the three divisions
    always_comb
    begin
        logic [VP_W-1:0]          nxm, nym;
        logic signed [DEN_W-1:0]  cwe, cze;
        logic [DEN_W-1:0]         cwm, czm;
        nxm = nx_reg[VP_W-1] ? VP_W'(-nx_reg) : VP_W'(nx_reg);
        nym = ny_reg[VP_W-1] ? VP_W'(-ny_reg) : VP_W'(ny_reg);
        cwe = DEN_W'(cw_reg);
        cze = DEN_W'(cz_reg);
        cwm = cwe[DEN_W-1] ? DEN_W'(-cwe) : DEN_W'(cwe);
        czm = cze[DEN_W-1] ? DEN_W'(-cze) : DEN_W'(cze);
        ops_next[LANE_X].num = NUM_W'(nxm) << FRAC_BITS;
        ops_next[LANE_X].den = cwm << 1;
        ops_next[LANE_X].neg = nx_reg[VP_W-1] ^ cw_reg[COORD_BITS-1];
        ops_next[LANE_Y].num = NUM_W'(nym) << FRAC_BITS;
        ops_next[LANE_Y].den = cwm << 1;
        ops_next[LANE_Y].neg = ny_reg[VP_W-1] ^ cw_reg[COORD_BITS-1];
        ops_next[LANE_Z].num = NUM_W'(czm) << FRAC_BITS;
        ops_next[LANE_Z].den = cwm;
        ops_next[LANE_Z].neg = cz_reg[COORD_BITS-1] ^ cw_reg[COORD_BITS-1];
    end

    // Valid bits advance with the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= vert_en;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    // Payload registers, held on stall
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg         <= prod_next;
            s1_be_reg        <= batch_end;
            clip_reg         <= clip_next;
            s2_tag_reg.batch_end <= s1_be_reg;
            s2_tag_reg.fault <= clip_fault_next;
            nx_reg           <= nx_next;
            ny_reg           <= ny_next;
            cz_reg           <= clip_reg[2];
            cw_reg           <= clip_reg[3];
            s3_tag_reg       <= s2_tag_reg;
            ops_reg          <= ops_next;
            s4_tag_reg       <= s3_tag_reg;
        end
    end

    assign out_valid = s4_valid_reg;
    assign out_ops   = ops_reg;
    assign out_tag   = s4_tag_reg;

endmodule

>>> design/vtvd_divider.sv
// Three-lane restoring divider, one quotient bit per pipeline stage after a seed stage.
// Overflow beyond the quotient width is found before the first bit; depends on vtvd_pkg.
module vtvd_divider (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        adv,
    input  logic                                        in_valid,
    input  vtvd_pkg::div_op_t [vtvd_pkg::NUM_LANES-1:0] in_ops,
    input  vtvd_pkg::vtvd_tag_t                         in_tag,
    output logic                                        out_valid,
    output vtvd_pkg::div_res_t [vtvd_pkg::NUM_LANES-1:0] out_res,
    output vtvd_pkg::vtvd_tag_t                         out_tag
);
    import vtvd_pkg::*;

    localparam int STAGES = Q_BITS + 1;

    logic      valid_reg [STAGES];
    vtvd_tag_t tag_reg   [STAGES];
    logic [NUM_W-1:0]  num_reg  [STAGES][NUM_LANES];
    logic [DEN_W-1:0]  den_reg  [STAGES][NUM_LANES];
    logic [REM_W-1:0]  rem_reg  [STAGES][NUM_LANES];
    logic [Q_BITS-1:0] quot_reg [STAGES][NUM_LANES];
    logic              ovf_reg  [STAGES][NUM_LANES];
    logic              neg_reg  [STAGES][NUM_LANES];
    logic [REM_W-1:0]  rem_next [STAGES][NUM_LANES];
    logic [Q_BITS-1:0] quot_next[STAGES][NUM_LANES];

    // First stage seeds the remainder; later stages each resolve one bit
    always_comb
    begin
        logic [REM_W-1:0] trial;
        logic             take;
        for (int l = 0; l < NUM_LANES; l++)
        begin
            rem_next[0][l]  = REM_W'(in_ops[l].num >> Q_BITS);
            quot_next[0][l] = '0;
        end
        for (int s = 1; s < STAGES; s++)
            for (int l = 0; l < NUM_LANES; l++)
            begin
                trial = {rem_reg[s-1][l][REM_W-2:0], num_reg[s-1][l][Q_BITS - s]};
                take  = trial >= REM_W'(den_reg[s-1][l]);
                rem_next[s][l]  = take ? trial - REM_W'(den_reg[s-1][l]) : trial;
                quot_next[s][l] = {quot_reg[s-1][l][Q_BITS-2:0], take};
            end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < STAGES; s++)
                valid_reg[s] <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg[0] <= in_valid;
            for (int s = 1; s < STAGES; s++)
                valid_reg[s] <= valid_reg[s-1];
        end
    end

    // Payload advances with the valid bits and holds on stall
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tag_reg[0] <= in_tag;
            for (int l = 0; l < NUM_LANES; l++)
            begin
                num_reg[0][l] <= in_ops[l].num;
                den_reg[0][l] <= in_ops[l].den;
                neg_reg[0][l] <= in_ops[l].neg;
                ovf_reg[0][l] <= (DEN_W + 1)'(in_ops[l].num >> Q_BITS)
                                 >= (DEN_W + 1)'(in_ops[l].den);
            end
            for (int s = 0; s < STAGES; s++)
                for (int l = 0; l < NUM_LANES; l++)
                begin
                    rem_reg[s][l]  <= rem_next[s][l];
                    quot_reg[s][l] <= quot_next[s][l];
                end
            for (int s = 1; s < STAGES; s++)
            begin
                tag_reg[s] <= tag_reg[s-1];
                for (int l = 0; l < NUM_LANES; l++)
                begin
                    num_reg[s][l] <= num_reg[s-1][l];
                    den_reg[s][l] <= den_reg[s-1][l];
                    neg_reg[s][l] <= neg_reg[s-1][l];
                    ovf_reg[s][l] <= ovf_reg[s-1][l];
                end
            end
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign out_tag   = tag_reg[STAGES-1];
    always_comb
    begin
        for (int l = 0; l < NUM_LANES; l++)
        begin
            out_res[l].quot = quot_reg[STAGES-1][l];
            out_res[l].ovf  = ovf_reg[STAGES-1][l];
            out_res[l].neg  = neg_reg[STAGES-1][l];
        end
    end

endmodule
